// ===== sv/stc_pkg.sv =====
package stc_pkg;

	localparam int unsigned CP_W    = 21;
	localparam int unsigned START_W = 32;
	localparam int unsigned ERR_W   = 3;
	localparam int unsigned MAP_W   = 64;
	localparam int unsigned NUM_MAP = 4;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [ERR_W-1:0] ERR_NONE  = 3'd0;
	localparam logic [ERR_W-1:0] ERR_NL    = 3'd1;
	localparam logic [ERR_W-1:0] ERR_EMPTY = 3'd2;
	localparam logic [ERR_W-1:0] ERR_QUOTE = 3'd3;
	localparam logic [ERR_W-1:0] ERR_COM   = 3'd4;

	typedef struct packed {
		logic [CP_W-1:0]    tok_char;
		logic               has_char;
		logic               tok_first;
		logic               tok_last;
		logic [START_W-1:0] tok_start;
		logic [ERR_W-1:0]   err_code;
	} res_t;

	// Results caused by one input item; the second is used only when two is set.
	typedef struct packed {
		logic two;
		res_t res0;
		res_t res1;
	} grp_t;

endpackage

// ===== sv/source_char_tokenizer.sv =====
// Source character tokenizer. One code point, with its lookahead, is accepted per cycle
// whenever the internal result queue has room; the lexer state updates in that same cycle,
// so consecutive beats never wait on each other. Each beat causes zero, one or two result
// beats, which pass through a queue of QUEUE_DEPTH groups and, unless out_stall is high,
// leave one per cycle from a registered output stage; an item with two results gives res0
// then res1. The input stalls only when the queue fills behind a stalled or slower output.
// The separator maps may be written at any time the block is idle and take effect at once.
module source_char_tokenizer #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [stc_pkg::CP_W-1:0]            code_point,
	input  logic [stc_pkg::CP_W-1:0]            next_point,
	input  logic                                is_end,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [stc_pkg::CP_W-1:0]            tok_char,
	output logic                                has_char,
	output logic                                tok_first,
	output logic                                tok_last,
	output logic [stc_pkg::START_W-1:0]         tok_start,
	output logic [stc_pkg::ERR_W-1:0]           err_code,
	input  logic                                cfg_we,
	input  logic [stc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [stc_pkg::MAP_W-1:0]           cfg_data
);

	logic          q_full;
	logic          q_push;
	logic          q_pop;
	logic          q_empty;
	stc_pkg::grp_t q_wdata;
	stc_pkg::grp_t q_rdata;
	stc_pkg::res_t res;

	stc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.code_point (code_point),
		.next_point (next_point),
		.is_end     (is_end),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (q_wdata)
	);

	stc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.empty     (q_empty)
	);

	stc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (q_rdata),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res)
	);

	assign tok_char  = res.tok_char;
	assign has_char  = res.has_char;
	assign tok_first = res.tok_first;
	assign tok_last  = res.tok_last;
	assign tok_start = res.tok_start;
	assign err_code  = res.err_code;

endmodule

// ===== sv/stc_front.sv =====
module stc_front (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [stc_pkg::CP_W-1:0]               code_point,
	input  logic [stc_pkg::CP_W-1:0]               next_point,
	input  logic                                   is_end,
	input  logic                                   cfg_we,
	input  logic [stc_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [stc_pkg::MAP_W-1:0]              cfg_data,
	input  logic                                   q_full,
	output logic                                   q_push,
	output stc_pkg::grp_t                          q_data
);

	localparam logic [2:0] M_BASE = 3'd0;
	localparam logic [2:0] M_WORD = 3'd1;
	localparam logic [2:0] M_STR  = 3'd2;
	localparam logic [2:0] M_CHR  = 3'd3;
	localparam logic [2:0] M_LCOM = 3'd4;
	localparam logic [2:0] M_MCOM = 3'd5;

	localparam logic [20:0] CH_TAB   = 21'h09;
	localparam logic [20:0] CH_LF    = 21'h0A;
	localparam logic [20:0] CH_CR    = 21'h0D;
	localparam logic [20:0] CH_SP    = 21'h20;
	localparam logic [20:0] CH_DQ    = 21'h22;
	localparam logic [20:0] CH_SQ    = 21'h27;
	localparam logic [20:0] CH_STAR  = 21'h2A;
	localparam logic [20:0] CH_DOT   = 21'h2E;
	localparam logic [20:0] CH_SLASH = 21'h2F;
	localparam logic [20:0] CH_0     = 21'h30;
	localparam logic [20:0] CH_9     = 21'h39;
	localparam logic [20:0] CH_BSL   = 21'h5C;
	localparam logic [20:0] CH_N     = 21'h6E;
	localparam logic [20:0] CH_R     = 21'h72;
	localparam logic [20:0] CH_T     = 21'h74;

	typedef struct packed {
		logic [2:0]  mode;
		logic        esc;
		logic [20:0] held_char;
		logic        held_valid;
		logic        held_first;
		logic [1:0]  tlen;
		logic        skip;
		logic [31:0] cidx;
		logic [31:0] tbeg;
	} lex_st_t;

	typedef struct packed {
		lex_st_t       st;
		stc_pkg::res_t res0;
		stc_pkg::res_t res1;
		logic [1:0]    n;
	} ctx_t;

	localparam lex_st_t LEX_RESET = '0;

	lex_st_t st_q;
	logic [stc_pkg::NUM_MAP-1:0][stc_pkg::MAP_W-1:0] sep_map_q;

	ctx_t        x;
	logic        accept;
	logic        sp;
	logic        sep;
	logic        map_hit;
	logic        dot_num;
	logic        empty;
	logic [20:0] close_ch;
	logic [2:0]  end_err;

	function automatic ctx_t f_emit(ctx_t xi, logic [20:0] ch, logic has, logic first,
			logic last, logic [2:0] err);
		stc_pkg::res_t r;
		ctx_t xo;
		xo = xi;
		r.tok_char  = ch;
		r.has_char  = has;
		r.tok_first = first;
		r.tok_last  = last;
		r.tok_start = xi.st.tbeg;
		r.err_code  = err;
		if (xi.n == 2'd0) begin
			xo.res0 = r;
		end else if (xi.n == 2'd1) begin
			xo.res1 = r;
		end
		if (xi.n != 2'd2) begin
			xo.n = xi.n + 2'd1;
		end
		return xo;
	endfunction

	function automatic ctx_t f_append(ctx_t xi, logic [20:0] c);
		ctx_t xo;
		xo = xi;
		if (xi.st.held_valid) begin
			xo = f_emit(xo, xi.st.held_char, 1'b1, xi.st.held_first, 1'b0,
				stc_pkg::ERR_NONE);
		end
		xo.st.held_char  = c;
		xo.st.held_valid = 1'b1;
		xo.st.held_first = (xi.st.tlen == 2'd0);
		if (xi.st.tlen != 2'd3) begin
			xo.st.tlen = xi.st.tlen + 2'd1;
		end
		return xo;
	endfunction

	function automatic ctx_t f_add(ctx_t xi, logic [20:0] c);
		ctx_t xo;
		logic [20:0] t;
		xo = xi;
		case (c)
			CH_T: t = CH_TAB;
			CH_N: t = CH_LF;
			CH_R: t = CH_CR;
			CH_BSL, CH_SQ, CH_DQ: t = c;
			default: t = '0;
		endcase
		if (c == CH_BSL && !xi.st.esc && (xi.st.mode == M_STR || xi.st.mode == M_CHR)) begin
			xo = f_append(xo, c);
			xo.st.esc = 1'b1;
		end else if (c != CH_CR) begin
			if (xi.st.esc && xi.st.held_valid && t != '0) begin
				xo.st.held_char = t;
				xo.st.esc = 1'b0;
			end else begin
				xo = f_append(xo, c);
				xo.st.esc = 1'b0;
			end
		end
		return xo;
	endfunction

	function automatic ctx_t f_push(ctx_t xi);
		ctx_t xo;
		xo = xi;
		if (xi.st.held_valid) begin
			xo = f_emit(xo, xi.st.held_char, 1'b1, xi.st.held_first, 1'b1,
				stc_pkg::ERR_NONE);
		end
		xo.st.held_valid = 1'b0;
		xo.st.held_char  = '0;
		xo.st.held_first = 1'b0;
		xo.st.tlen       = 2'd0;
		return xo;
	endfunction

	function automatic ctx_t f_base(ctx_t xi, logic [20:0] c, logic [20:0] nx, logic is_sp,
			logic is_sep);
		ctx_t xo;
		xo = xi;
		xo.st.tbeg = xi.st.cidx;
		if (!is_sp) begin
			if (c == CH_SLASH && nx == CH_SLASH) begin
				xo.st.mode = M_LCOM;
			end else if (c == CH_SLASH && nx == CH_STAR) begin
				xo.st.mode = M_MCOM;
			end else if (is_sep) begin
				xo = f_add(xo, c);
				xo = f_push(xo);
			end else if (c == CH_SQ) begin
				xo = f_add(xo, c);
				xo.st.mode = M_CHR;
			end else if (c == CH_DQ) begin
				xo = f_add(xo, c);
				xo.st.mode = M_STR;
			end else begin
				xo.st.mode = M_WORD;
				xo = f_add(xo, c);
			end
		end
		return xo;
	endfunction

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	always_comb begin
		sp      = code_point inside {CH_SP, [CH_TAB:CH_CR]};
		dot_num = (code_point == CH_DOT) && (next_point inside {[CH_0:CH_9]});
		map_hit = (code_point[20:8] == '0) && sep_map_q[code_point[7:6]][code_point[5:0]];
		sep     = !dot_num && (map_hit || sp);
	end

	always_comb begin
		x.st   = st_q;
		x.res0 = '0;
		x.res1 = '0;
		x.n    = 2'd0;
		empty  = 1'b0;
		close_ch = (st_q.mode == M_STR) ? CH_DQ : CH_SQ;
		end_err  = stc_pkg::ERR_NONE;
		if (is_end) begin
			x = f_push(x);
			if (st_q.mode == M_STR || st_q.mode == M_CHR) begin
				end_err = stc_pkg::ERR_QUOTE;
			end else if (st_q.mode == M_MCOM) begin
				end_err = stc_pkg::ERR_COM;
			end
			if (end_err != stc_pkg::ERR_NONE) begin
				if (x.n == 2'd1) begin
					x.res0.err_code = end_err;
				end else if (x.n == 2'd2) begin
					x.res1.err_code = end_err;
				end else begin
					x = f_emit(x, '0, 1'b0, 1'b0, 1'b0, end_err);
				end
			end
			x.st = LEX_RESET;
		end else if (st_q.skip) begin
			x.st.skip = 1'b0;
			x.st.cidx = st_q.cidx + 32'd1;
		end else begin
			case (st_q.mode)
				M_BASE: begin
					x = f_base(x, code_point, next_point, sp, sep);
				end
				M_WORD: begin
					if (sep) begin
						x = f_push(x);
						x.st.mode = M_BASE;
						x = f_base(x, code_point, next_point, sp, sep);
					end else begin
						x = f_add(x, code_point);
					end
				end
				M_STR, M_CHR: begin
					if (code_point == close_ch && !st_q.esc) begin
						x = f_add(x, code_point);
						empty = (st_q.mode == M_CHR) && (x.st.tlen == 2'd2);
						x = f_push(x);
						if (empty && x.n == 2'd1) begin
							x.res0.err_code = stc_pkg::ERR_EMPTY;
						end else if (empty && x.n == 2'd2) begin
							x.res1.err_code = stc_pkg::ERR_EMPTY;
						end
						x.st.mode = M_BASE;
					end else if (code_point == CH_LF) begin
						x = f_emit(x, '0, 1'b0, 1'b0, 1'b0, stc_pkg::ERR_NL);
					end else begin
						x = f_add(x, code_point);
					end
				end
				M_LCOM: begin
					if (code_point == CH_LF) begin
						x.st.mode = M_BASE;
					end
				end
				M_MCOM: begin
					if (code_point == CH_STAR && next_point == CH_SLASH) begin
						x.st.skip = 1'b1;
						x.st.mode = M_BASE;
					end
				end
				default: begin
					x.st.mode = M_BASE;
				end
			endcase
			x.st.cidx = x.st.cidx + 32'd1;
		end
	end

	assign q_push      = accept && (x.n != 2'd0);
	assign q_data.two  = (x.n == 2'd2);
	assign q_data.res0 = x.res0;
	assign q_data.res1 = x.res1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= LEX_RESET;
		end else if (accept) begin
			st_q <= x.st;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_map_q <= '0;
		end else if (cfg_we) begin
			sep_map_q[cfg_index] <= cfg_data;
		end
	end

endmodule

// ===== sv/stc_queue.sv =====
module stc_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  stc_pkg::grp_t push_data,
	output logic          full,
	input  logic          pop,
	output stc_pkg::grp_t pop_data,
	output logic          empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	stc_pkg::grp_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full     = (count_q == FULL_CNT);
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== sv/stc_back.sv =====
module stc_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  stc_pkg::grp_t q_data,
	output logic          q_pop,
	output logic          out_valid,
	input  logic          out_stall,
	output stc_pkg::res_t res
);

	stc_pkg::grp_t grp_q;
	logic          valid_q;
	logic          sel_q;
	logic          advance;
	logic          second;

	assign out_valid = valid_q;
	assign res       = sel_q ? grp_q.res1 : grp_q.res0;
	assign advance   = !valid_q || !out_stall;
	assign second    = valid_q && !sel_q && grp_q.two;
	assign q_pop     = advance && !second && !q_empty;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			grp_q <= q_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q   <= 1'b0;
		end else if (advance) begin
			if (second) begin
				sel_q <= 1'b1;
			end else if (!q_empty) begin
				valid_q <= 1'b1;
				sel_q   <= 1'b0;
			end else begin
				valid_q <= 1'b0;
				sel_q   <= 1'b0;
			end
		end
	end

endmodule
